// ===== rtl/core/ipid_pkg.sv =====
`default_nettype none

package ipid_pkg;

   localparam int IN_W      = 16;
   localparam int ERR_W     = IN_W + 1;
   localparam int DIFF1_W   = ERR_W + 1;
   localparam int DIFF2_W   = ERR_W + 2;
   localparam int GAIN_W    = 24;
   localparam int LIMIT_W   = 31;
   localparam int DRIVE_W   = 32;
   localparam int PROD_W    = GAIN_W + DIFF2_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   typedef logic signed [GAIN_W-1:0]  gain_type;
   typedef logic        [LIMIT_W-1:0] limit_type;
   typedef logic signed [DRIVE_W-1:0] drive_type;
   typedef logic signed [PROD_W-1:0]  prod_type;

   typedef enum logic [1:0] {
      REG_KP    = 2'd0,
      REG_KI    = 2'd1,
      REG_KD    = 2'd2,
      REG_LIMIT = 2'd3
   } csr_reg_type;

   typedef struct packed {
      prod_type p_term;
      prod_type i_term;
      prod_type d_term;
   } terms_type;

endpackage

`default_nettype wire

// ===== rtl/core/ipid_clamp.sv =====
`default_nettype none

module ipid_clamp import ipid_pkg::*; (
   input  drive_type acc,
   input  terms_type terms,
   input  limit_type limit,
   output drive_type drive
);

   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] pos_lim;
   logic signed [SUM_W-1:0] neg_lim;

   // exact wide sum: no wrap is possible at this width
   assign sum = SUM_W'(acc)
              + SUM_W'(terms.p_term)
              + SUM_W'(terms.i_term)
              + SUM_W'(terms.d_term);

   assign pos_lim = $signed({{(SUM_W-LIMIT_W){1'b0}}, limit});
   assign neg_lim = -pos_lim;

   always_comb begin
      priority if (sum > pos_lim) begin
         drive = pos_lim[DRIVE_W-1:0];
      end else if (sum < neg_lim) begin
         drive = neg_lim[DRIVE_W-1:0];
      end else begin
         drive = sum[DRIVE_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/incremental_pid_controller_unit.sv =====
// A request beat passes through the error stage, the product stage and the accumulate-and-clamp
// stage, in that order, before its result is valid; a stalled result holds the stages behind it.
// Throughput: one beat per cycle while rsp_stall is low; the drive register closes a loop
// through the add and clamp, so consecutive samples never wait on each other.
// Reset (synchronous): clears gains, limit, drive, error history and all valid flags.
`default_nettype none

module incremental_pid_controller_unit import ipid_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [IN_W-1:0]  req_setpoint,
   input  logic signed [IN_W-1:0]  req_measured,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [DRIVE_W-1:0] rsp_drive,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   // configuration
   gain_type  kp_ff, kp_in;
   gain_type  ki_ff, ki_in;
   gain_type  kd_ff, kd_in;
   limit_type limit_ff, limit_in;
   logic      csr_wr;
   csr_reg_type csr_sel;

   // error history and stage 1
   logic signed [ERR_W-1:0]   last_err_ff, prev_err_ff;
   logic signed [ERR_W-1:0]   err;
   logic signed [DIFF1_W-1:0] d1;
   logic signed [DIFF2_W-1:0] d2;
   logic                      s1_valid_ff, s1_valid_in;
   logic signed [DIFF2_W-1:0] s1_err_ff, s1_d1_ff, s1_d2_ff;

   // stage 2
   logic      s2_valid_ff, s2_valid_in;
   terms_type s2_terms_ff, s2_terms_in;

   // result / accumulator
   logic      rsp_valid_ff, rsp_valid_in;
   drive_type drive_ff, drive_next;

   logic rsp_free, s2_take, s1_load;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_sel    = csr_reg_type'(csr_paddr[3:2]);

   always_comb begin
      kp_in    = kp_ff;
      ki_in    = ki_ff;
      kd_in    = kd_ff;
      limit_in = limit_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            REG_KP:    kp_in    = csr_pwdata[GAIN_W-1:0];
            REG_KI:    ki_in    = csr_pwdata[GAIN_W-1:0];
            REG_KD:    kd_in    = csr_pwdata[GAIN_W-1:0];
            REG_LIMIT: limit_in = csr_pwdata[LIMIT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_KP:    csr_prdata = CSR_DATA_W'(kp_ff);
         REG_KI:    csr_prdata = CSR_DATA_W'(ki_ff);
         REG_KD:    csr_prdata = CSR_DATA_W'(kd_ff);
         REG_LIMIT: csr_prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, limit_ff};
      endcase
   end

   // flow control: each stage moves when the next one is empty or moving
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_take   = s1_valid_ff && (!s2_valid_ff || rsp_free);
   assign req_stall = s1_valid_ff && s2_valid_ff && !rsp_free;
   assign s1_load   = req_valid && !req_stall;

   // error and its differences against the history
   assign err = {req_setpoint[IN_W-1], req_setpoint} - {req_measured[IN_W-1], req_measured};
   assign d1  = {err[ERR_W-1], err} - {last_err_ff[ERR_W-1], last_err_ff};
   assign d2  = {{2{err[ERR_W-1]}}, err}
              - {last_err_ff[ERR_W-1], last_err_ff, 1'b0}
              + {{2{prev_err_ff[ERR_W-1]}}, prev_err_ff};

   always_comb begin
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (s2_take) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s2_take) begin
         s2_valid_in = 1'b1;
      end else if (rsp_free) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end

      if (s2_valid_ff && rsp_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign s2_terms_in.p_term = PROD_W'(kp_ff) * PROD_W'(s1_d1_ff);
   assign s2_terms_in.i_term = PROD_W'(ki_ff) * PROD_W'(s1_err_ff);
   assign s2_terms_in.d_term = PROD_W'(kd_ff) * PROD_W'(s1_d2_ff);

   ipid_clamp u_clamp (
      .acc   (drive_ff),
      .terms (s2_terms_ff),
      .limit (limit_ff),
      .drive (drive_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         limit_ff     <= '0;
         last_err_ff  <= '0;
         prev_err_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         drive_ff     <= '0;
      end else begin
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         limit_ff     <= limit_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // shift the history on every accepted beat
         if (s1_load) begin
            prev_err_ff <= last_err_ff;
            last_err_ff <= err;
         end
         if (s2_valid_ff && rsp_free) begin
            drive_ff <= drive_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_err_ff <= {{2{err[ERR_W-1]}}, err};
         s1_d1_ff  <= {d1[DIFF1_W-1], d1};
         s1_d2_ff  <= d2;
      end
      if (s2_take) begin
         s2_terms_ff <= s2_terms_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = drive_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ipid_checker.sv =====
`default_nettype none

module ipid_checker import ipid_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [DRIVE_W-1:0] rsp_drive,
   input logic                      csr_psel,
   input logic                      csr_penable,
   input logic                      csr_pwrite,
   input logic [CSR_ADDR_W-1:0]     csr_paddr,
   input logic [CSR_DATA_W-1:0]     csr_pwdata,
   input logic                      csr_pready
);

   limit_type lim_ff;
   logic [2:0] pend_ff;
   logic       req_beat, rsp_beat;
   logic signed [DRIVE_W:0] lim_pos, drive_ext;

   assign req_beat  = req_valid && !req_stall;
   assign rsp_beat  = rsp_valid && !rsp_stall;
   assign lim_pos   = $signed({2'b00, lim_ff});
   assign drive_ext = $signed({rsp_drive[DRIVE_W-1], rsp_drive});

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff  <= '0;
         pend_ff <= '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_reg_type'(csr_paddr[3:2]) == REG_LIMIT) begin
            lim_ff <= csr_pwdata[LIMIT_W-1:0];
         end
         pend_ff <= pend_ff + 3'(req_beat) - 3'(rsp_beat);
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive))
      else $error("stalled result beat changed");

   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (drive_ext <= lim_pos) && (drive_ext >= -lim_pos))
      else $error("drive outside configured limit");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 3'd0)
      else $error("result beat without a pending request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd3)
      else $error("more beats in flight than pipeline stages");

endmodule

bind incremental_pid_controller_unit ipid_checker u_ipid_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench import ipid_pkg::*; ();

   typedef struct {
      logic signed [IN_W-1:0] setpoint;
      logic signed [IN_W-1:0] measured;
   } sample_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [IN_W-1:0]    req_setpoint = '0;
   logic signed [IN_W-1:0]    req_measured = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [DRIVE_W-1:0] rsp_drive;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;

   // predictor copy of the configuration and loop state
   gain_type  kp_gain = '0;
   gain_type  ki_gain = '0;
   gain_type  kd_gain = '0;
   limit_type limit_mag = '0;
   longint    drive_now = 0;
   longint    err_last = 0;
   longint    err_prev = 0;

   sample_type samples_pending[$];
   drive_type  drive_expected[$];
   int         send_idle_pct = 33;
   int         recv_stall_pct = 47;
   int         mismatch_count = 0;
   int         drive_seen = 0;

   incremental_pid_controller_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_setpoint (req_setpoint),
      .req_measured (req_measured),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_drive    (rsp_drive),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] %s", $time, what);
   endtask

   // velocity-form update: exact wide sum, then clamp to +/- limit
   function automatic void predict_drive(input logic signed [IN_W-1:0] sp,
                                         input logic signed [IN_W-1:0] mv);
      longint err;
      longint d1;
      longint d2;
      longint kp;
      longint ki;
      longint kd;
      longint lim;
      longint acc;
      err = longint'(sp) - longint'(mv);
      d1  = err - err_last;
      d2  = err - 2 * err_last + err_prev;
      kp  = kp_gain;
      ki  = ki_gain;
      kd  = kd_gain;
      lim = limit_mag;
      acc = drive_now + kp * d1 + ki * err + kd * d2;
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      drive_now = acc;
      err_prev  = err_last;
      err_last  = err;
      drive_expected.push_back(drive_type'(acc));
   endfunction

   task automatic write_csr(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // bits above the register width are dropped
      case (idx)
         REG_KP:    kp_gain = value[GAIN_W-1:0];
         REG_KI:    ki_gain = value[GAIN_W-1:0];
         REG_KD:    kd_gain = value[GAIN_W-1:0];
         REG_LIMIT: limit_mag = value[LIMIT_W-1:0];
         default:   ;
      endcase
   endtask

   task automatic enqueue(input logic signed [IN_W-1:0] sp, input logic signed [IN_W-1:0] mv);
      sample_type s;
      s.setpoint = sp;
      s.measured = mv;
      samples_pending.push_back(s);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (samples_pending.size() != 0 || req_valid || drive_expected.size() != 0);
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_gain();
      logic [GAIN_W-1:0] g;
      case ($urandom_range(3))
         0:       g = GAIN_W'($urandom);
         1, 2:    g = GAIN_W'($urandom_range(131072)) - GAIN_W'(65536);
         default: g = '0;
      endcase
      return {8'($urandom), g};
   endfunction

   always @(posedge clock) begin : drive_requests
      sample_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_drive(req_setpoint, req_measured);
         if (!req_valid || !req_stall) begin
            if (samples_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               beat = samples_pending.pop_front();
               req_valid    <= 1'b1;
               req_setpoint <= beat.setpoint;
               req_measured <= beat.measured;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin : check_drive
      drive_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected drive beat %0d: %0d", drive_seen, rsp_drive));
         end else begin
            want = drive_expected.pop_front();
            if (rsp_drive !== want)
               report_mismatch($sformatf("drive beat %0d: got %0d, want %0d",
                                         drive_seen, rsp_drive, want));
         end
         drive_seen++;
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0]  raw;
      logic signed [IN_W-1:0] sp;
      logic signed [IN_W-1:0] mv;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: zero limit pins the drive at zero
      enqueue(16'sh7fff, 16'sh8000);
      enqueue(16'sh8000, 16'sh7fff);
      wait_idle();

      write_csr(REG_KP, 32'h0001_0000);
      write_csr(REG_KI, 32'h0000_4000);
      write_csr(REG_KD, 32'h0000_8000);
      write_csr(REG_LIMIT, 32'h7fff_ffff);
      enqueue(16'sd100, 16'sd0);
      enqueue(16'sd100, 16'sd50);
      enqueue(16'sd0, 16'sd0);
      enqueue(16'sh8000, 16'sh7fff);
      enqueue(16'sh7fff, 16'sh8000);
      enqueue(16'sd0, 16'sd0);
      enqueue(16'sh7fff, 16'sh7fff);
      enqueue(16'sh8000, 16'sh8000);
      wait_idle();

      // extreme gains with junk in the upper byte: increments far past the limit
      write_csr(REG_KP, 32'ha580_0000);
      write_csr(REG_KI, 32'h5a7f_ffff);
      write_csr(REG_KD, 32'hff80_0000);
      enqueue(16'sh7fff, 16'sh8000);
      enqueue(16'sh8000, 16'sh7fff);
      enqueue(16'sh7fff, 16'sh8000);
      enqueue(16'sd0, 16'sd0);
      wait_idle();

      // only the dropped top bit is set, so the limit is zero
      write_csr(REG_LIMIT, 32'h8000_0000);
      enqueue(16'sd1000, -16'sd1000);
      enqueue(-16'sd5, 16'sd5);
      wait_idle();

      write_csr(REG_LIMIT, 32'h0000_0001);
      write_csr(REG_KD, 32'h007f_ffff);
      enqueue(16'sd7, 16'sd3);
      enqueue(-16'sd7, 16'sd3);
      wait_idle();

      for (int phase = 0; phase < 14; phase++) begin
         if (phase < 5) begin
            send_idle_pct = 33;
            recv_stall_pct = 47;
         end else if (phase < 10) begin
            send_idle_pct = 47;
            recv_stall_pct = 33;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         write_csr(REG_KP, random_gain());
         write_csr(REG_KI, random_gain());
         write_csr(REG_KD, random_gain());
         case ($urandom_range(7))
            0:       raw = '0;
            1, 2:    raw = {1'($urandom), 31'h7fff_ffff};
            3, 4:    raw = $urandom;
            default: raw = $urandom_range(32'h0100_0000);
         endcase
         write_csr(REG_LIMIT, raw);
         for (int n = 0; n < 125; n++) begin
            sp = IN_W'($urandom);
            case ($urandom_range(4))
               0, 1: mv = sp + IN_W'($urandom_range(400)) - IN_W'(200);
               2, 3: mv = IN_W'($urandom);
               default: begin
                  sp = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                  mv = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
               end
            endcase
            enqueue(sp, mv);
         end
         wait_idle();
      end

      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && drive_expected.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/ipid_pkg.sv
rtl/core/ipid_clamp.sv
rtl/core/incremental_pid_controller_unit.sv
rtl/core/ipid_checker.sv
test/testbench.sv
